[src/pfpu_pkg.sv]
package pfpu_pkg;

	localparam int WORD_W   = 32;
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int REG_W    = 5;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	localparam int CHAN_MAX   = 255;
	localparam int ROUND_BIAS = 127;

	typedef enum logic [2:0] {
		REG_RED_OFFSET   = 3'd0,
		REG_RED_LENGTH   = 3'd1,
		REG_GREEN_OFFSET = 3'd2,
		REG_GREEN_LENGTH = 3'd3,
		REG_BLUE_OFFSET  = 3'd4,
		REG_BLUE_LENGTH  = 3'd5,
		REG_ALPHA_OFFSET = 3'd6,
		REG_ALPHA_LENGTH = 3'd7
	} reg_idx_t;

	typedef enum logic {
		KIND_PACK   = 1'b0,
		KIND_UNPACK = 1'b1
	} kind_t;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		logic [REG_W-1:0] offset;
		logic [REG_W-1:0] length;
	} chan_cfg_t;

	typedef chan_cfg_t [NUM_CHAN-1:0] cfg_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

	localparam cfg_t CFG_RESET = '{
		'{offset: 5'd24, length: 5'd8},
		'{offset: 5'd16, length: 5'd8},
		'{offset: 5'd8,  length: 5'd8},
		'{offset: 5'd0,  length: 5'd8}
	};

	function automatic logic [REG_W-1:0] eff_len(logic [REG_W-1:0] len, int unsigned max_bits);
		logic [REG_W-1:0] res;
		res = len;
		if (int'(len) > int'(max_bits)) begin
			res = REG_W'(max_bits);
		end
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] word_mask(int unsigned bits);
		logic [63:0] m;
		m = (64'd1 << bits) - 64'd1;
		return m[WORD_W-1:0];
	endfunction

endpackage

[src/pfpu_if.sv]
interface pfpu_pixel_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [pfpu_pkg::CHAN_W-1:0]  red_in;
	logic [pfpu_pkg::CHAN_W-1:0]  green_in;
	logic [pfpu_pkg::CHAN_W-1:0]  blue_in;
	logic [pfpu_pkg::CHAN_W-1:0]  alpha_in;
	logic [pfpu_pkg::WORD_W-1:0]  word_in;

	modport source (output valid, kind, red_in, green_in, blue_in, alpha_in, word_in,
		input ready);
	modport sink (input valid, kind, red_in, green_in, blue_in, alpha_in, word_in,
		output ready);
endinterface

interface pfpu_result_if;
	logic                         valid;
	logic                         ready;
	logic [pfpu_pkg::WORD_W-1:0]  word_out;
	logic [pfpu_pkg::CHAN_W-1:0]  red_out;
	logic [pfpu_pkg::CHAN_W-1:0]  green_out;
	logic [pfpu_pkg::CHAN_W-1:0]  blue_out;
	logic [pfpu_pkg::CHAN_W-1:0]  alpha_out;

	modport source (output valid, word_out, red_out, green_out, blue_out, alpha_out,
		input ready);
	modport sink (input valid, word_out, red_out, green_out, blue_out, alpha_out,
		output ready);
endinterface

[src/pfpu_cfg.sv]
module pfpu_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfpu_pkg::ADDR_W-1:0]   paddr,
	input  logic [pfpu_pkg::DATA_W-1:0]   pwdata,
	output logic [pfpu_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pfpu_pkg::cfg_t                cfg
);

	pfpu_pkg::cfg_t     cfg_q;
	pfpu_pkg::reg_idx_t idx;
	logic               wr_en;
	logic [pfpu_pkg::REG_W-1:0] wval;
	logic [pfpu_pkg::REG_W-1:0] rval;

	assign pready = 1'b1;
	assign idx    = pfpu_pkg::reg_idx_t'(paddr[pfpu_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign wval   = pwdata[pfpu_pkg::REG_W-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pfpu_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				pfpu_pkg::REG_RED_OFFSET:   cfg_q[pfpu_pkg::CH_RED].offset   <= wval;
				pfpu_pkg::REG_RED_LENGTH:   cfg_q[pfpu_pkg::CH_RED].length   <= wval;
				pfpu_pkg::REG_GREEN_OFFSET: cfg_q[pfpu_pkg::CH_GREEN].offset <= wval;
				pfpu_pkg::REG_GREEN_LENGTH: cfg_q[pfpu_pkg::CH_GREEN].length <= wval;
				pfpu_pkg::REG_BLUE_OFFSET:  cfg_q[pfpu_pkg::CH_BLUE].offset  <= wval;
				pfpu_pkg::REG_BLUE_LENGTH:  cfg_q[pfpu_pkg::CH_BLUE].length  <= wval;
				pfpu_pkg::REG_ALPHA_OFFSET: cfg_q[pfpu_pkg::CH_ALPHA].offset <= wval;
				pfpu_pkg::REG_ALPHA_LENGTH: cfg_q[pfpu_pkg::CH_ALPHA].length <= wval;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pfpu_pkg::REG_RED_OFFSET:   rval = cfg_q[pfpu_pkg::CH_RED].offset;
			pfpu_pkg::REG_RED_LENGTH:   rval = cfg_q[pfpu_pkg::CH_RED].length;
			pfpu_pkg::REG_GREEN_OFFSET: rval = cfg_q[pfpu_pkg::CH_GREEN].offset;
			pfpu_pkg::REG_GREEN_LENGTH: rval = cfg_q[pfpu_pkg::CH_GREEN].length;
			pfpu_pkg::REG_BLUE_OFFSET:  rval = cfg_q[pfpu_pkg::CH_BLUE].offset;
			pfpu_pkg::REG_BLUE_LENGTH:  rval = cfg_q[pfpu_pkg::CH_BLUE].length;
			pfpu_pkg::REG_ALPHA_OFFSET: rval = cfg_q[pfpu_pkg::CH_ALPHA].offset;
			pfpu_pkg::REG_ALPHA_LENGTH: rval = cfg_q[pfpu_pkg::CH_ALPHA].length;
		endcase
		prdata = pfpu_pkg::DATA_W'(rval);
	end

endmodule

[src/pfpu_lane.sv]
module pfpu_lane #(
	parameter int MAX_FIELD_BITS = 16,
	parameter int WORD_BITS      = 32
) (
	input  logic                             clk,
	input  logic [(MAX_FIELD_BITS+1)/2:0]    stage_en,
	input  pfpu_pkg::kind_t                  kind,
	input  pfpu_pkg::chan_t                  chan_in,
	input  logic [pfpu_pkg::WORD_W-1:0]      word_in,
	input  pfpu_pkg::chan_cfg_t              cfg,
	output logic [MAX_FIELD_BITS-1:0]        quo
);

	localparam int QB   = MAX_FIELD_BITS;
	localparam int NSTG = (MAX_FIELD_BITS + 1) / 2;
	localparam int QS   = 2 * NSTG;
	localparam int NW   = QB + pfpu_pkg::CHAN_W;
	localparam int CW   = QB + QS;

	logic [pfpu_pkg::REG_W-1:0]  len_eff;
	logic [NW-1:0]               m_wide;
	logic [QB-1:0]               fmask;
	logic [pfpu_pkg::WORD_W-1:0] field_w;
	logic [QB-1:0]               field;
	logic [NW-1:0]               pk_num;
	logic [NW-1:0]               up_num;
	logic [NW-1:0]               num;
	logic [QB-1:0]               den;

	logic [NW-1:0] rem_s [NSTG+1];
	logic [QB-1:0] den_s [NSTG+1];
	logic [QS-1:0] quo_s [NSTG+1];

	// front end: numerator/divisor for round(v*M/255) or floor(f*255/M)
	always_comb begin
		len_eff = pfpu_pkg::eff_len(cfg.length, QB);
		m_wide  = (NW'(1) << len_eff) - NW'(1);
		fmask   = m_wide[QB-1:0];
		pk_num  = (NW'(chan_in) << len_eff) - NW'(chan_in) + NW'(pfpu_pkg::ROUND_BIAS);
		field_w = (word_in & pfpu_pkg::word_mask(WORD_BITS)) >> cfg.offset;
		field   = field_w[QB-1:0] & fmask;
		up_num  = (NW'(field) << pfpu_pkg::CHAN_W) - NW'(field);
		if (kind == pfpu_pkg::KIND_UNPACK) begin
			num = up_num;
			den = fmask;
		end else begin
			num = pk_num;
			den = QB'(pfpu_pkg::CHAN_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	// restoring divider, two quotient bits per stage
	for (genvar k = 0; k < NSTG; k++) begin : g_div
		logic [NW-1:0] r;
		logic [QS-1:0] q;
		logic [CW-1:0] sh;

		always_comb begin
			r  = rem_s[k];
			q  = quo_s[k];
			sh = '0;
			for (int j = 0; j < 2; j++) begin
				sh = CW'(den_s[k]) << (QS - 1 - 2 * k - j);
				if (CW'(r) >= sh) begin
					r = r - sh[NW-1:0];
					q[QS-1-2*k-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[k+1]) begin
				rem_s[k+1] <= r;
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= q;
			end
		end
	end

	assign quo = quo_s[NSTG][QB-1:0];

endmodule

[src/pfpu_merge.sv]
module pfpu_merge #(
	parameter int MAX_FIELD_BITS = 16,
	parameter int WORD_BITS      = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  pfpu_pkg::ctl_t                                ctl,
	input  logic [pfpu_pkg::NUM_CHAN-1:0][MAX_FIELD_BITS-1:0] quo,
	input  pfpu_pkg::cfg_t                                cfg,
	output logic                                          take,
	pfpu_result_if.source                                 result
);

	logic                        valid_q;
	logic [pfpu_pkg::WORD_W-1:0] word_q;
	pfpu_pkg::chan_t             chan_q [pfpu_pkg::NUM_CHAN];

	logic [pfpu_pkg::WORD_W-1:0] word_c;
	logic [63:0]                 sh;
	pfpu_pkg::chan_t             chan_c [pfpu_pkg::NUM_CHAN];

	assign take = !valid_q || result.ready;

	always_comb begin
		word_c = '0;
		sh     = '0;
		for (int ch = 0; ch < pfpu_pkg::NUM_CHAN; ch++) begin
			sh     = 64'(quo[ch]) << cfg[ch].offset;
			word_c = word_c | sh[pfpu_pkg::WORD_W-1:0];
			if (cfg[ch].length == '0 || ctl.kind == pfpu_pkg::KIND_PACK) begin
				chan_c[ch] = '0;
			end else begin
				chan_c[ch] = quo[ch][pfpu_pkg::CHAN_W-1:0];
			end
		end
		word_c = word_c & pfpu_pkg::word_mask(WORD_BITS);
		if (ctl.kind == pfpu_pkg::KIND_UNPACK) begin
			word_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl.valid) begin
			word_q <= word_c;
			chan_q <= chan_c;
		end
	end

	assign result.valid     = valid_q;
	assign result.word_out  = word_q;
	assign result.red_out   = chan_q[pfpu_pkg::CH_RED];
	assign result.green_out = chan_q[pfpu_pkg::CH_GREEN];
	assign result.blue_out  = chan_q[pfpu_pkg::CH_BLUE];
	assign result.alpha_out = chan_q[pfpu_pkg::CH_ALPHA];

endmodule

[src/pixel_format_pack_unpack_core.sv]
// Converts one pixel per clock, unless stalled, between four 8-bit RGBA channels (kind
// 0, pack) and a framebuffer word (kind 1, unpack) whose channel fields sit at the
// offsets and lengths held in the eight APB registers. Each channel runs in its own
// lane; the scaling divide is a restoring divider pipelined two quotient bits per
// stage, so a transaction passes an input register, the divider stages and an output
// register on its way to the result, and a new pixel is taken every cycle while the
// output is not stalled. Stages with a free slot keep taking pixels while a result
// waits at the output. Registers may be written only when no pixel is in flight.
module pixel_format_pack_unpack_core #(
	parameter int MAX_FIELD_BITS = 16,
	parameter int WORD_BITS      = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfpu_pkg::ADDR_W-1:0]   paddr,
	input  logic [pfpu_pkg::DATA_W-1:0]   pwdata,
	output logic [pfpu_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	pfpu_pixel_if.sink                    pixel,
	pfpu_result_if.source                 result
);

	localparam int NSTG = (MAX_FIELD_BITS + 1) / 2;

	pfpu_pkg::cfg_t  cfg;
	pfpu_pkg::ctl_t  ctl_s [NSTG+1];
	logic [NSTG+1:0] rdy;
	logic            take;
	pfpu_pkg::chan_t pix_chan [pfpu_pkg::NUM_CHAN];
	logic [pfpu_pkg::NUM_CHAN-1:0][MAX_FIELD_BITS-1:0] quo;

	pfpu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign pix_chan[pfpu_pkg::CH_RED]   = pixel.red_in;
	assign pix_chan[pfpu_pkg::CH_GREEN] = pixel.green_in;
	assign pix_chan[pfpu_pkg::CH_BLUE]  = pixel.blue_in;
	assign pix_chan[pfpu_pkg::CH_ALPHA] = pixel.alpha_in;

	// per-stage ready chain, lets bubbles collapse behind a stalled output
	always_comb begin
		rdy[NSTG+1] = take;
		for (int k = NSTG; k >= 0; k--) begin
			rdy[k] = !ctl_s[k].valid || rdy[k+1];
		end
	end

	assign pixel.ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTG; k++) begin
				ctl_s[k] <= '{valid: 1'b0, kind: pfpu_pkg::KIND_PACK};
			end
		end else begin
			if (rdy[0]) begin
				ctl_s[0] <= '{valid: pixel.valid, kind: pfpu_pkg::kind_t'(pixel.kind)};
			end
			for (int k = 0; k < NSTG; k++) begin
				if (rdy[k+1]) begin
					ctl_s[k+1] <= ctl_s[k];
				end
			end
		end
	end

	for (genvar ch = 0; ch < pfpu_pkg::NUM_CHAN; ch++) begin : g_lane
		pfpu_lane #(
			.MAX_FIELD_BITS (MAX_FIELD_BITS),
			.WORD_BITS      (WORD_BITS)
		) u_lane (
			.clk      (clk),
			.stage_en (rdy[NSTG:0]),
			.kind     (pfpu_pkg::kind_t'(pixel.kind)),
			.chan_in  (pix_chan[ch]),
			.word_in  (pixel.word_in),
			.cfg      (cfg[ch]),
			.quo      (quo[ch])
		);
	end

	pfpu_merge #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS),
		.WORD_BITS      (WORD_BITS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s[NSTG]),
		.quo    (quo),
		.cfg    (cfg),
		.take   (take),
		.result (result)
	);

endmodule

[src/pfpu_chk.sv]
module pfpu_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pfpu_pkg::WORD_W-1:0]  word_out,
	input logic [pfpu_pkg::CHAN_W-1:0]  red_out,
	input logic [pfpu_pkg::CHAN_W-1:0]  green_out,
	input logic [pfpu_pkg::CHAN_W-1:0]  blue_out,
	input logic [pfpu_pkg::CHAN_W-1:0]  alpha_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(word_out) && $stable(red_out) &&
			$stable(green_out) && $stable(blue_out) && $stable(alpha_out))
		else $error("result payload changed while stalled");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_out != '0 |-> red_out == '0 && green_out == '0 &&
			blue_out == '0 && alpha_out == '0)
		else $error("packed word and channels both nonzero");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind pixel_format_pack_unpack_core pfpu_chk u_pfpu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.word_out  (result.word_out),
	.red_out   (result.red_out),
	.green_out (result.green_out),
	.blue_out  (result.blue_out),
	.alpha_out (result.alpha_out)
);
